[rtl/core/wrb_pkg.sv]
// shared types and constants for the write redirect buffer
package wrb_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int STORE_BYTES = 256;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int OFF_W       = $clog2(STORE_BYTES);
    localparam int NXT_W       = $clog2(STORE_BYTES + 3);

    localparam logic [1:0] FUNC_READ   = 2'd0;
    localparam logic [1:0] FUNC_WRITE  = 2'd1;
    localparam logic [1:0] FUNC_COMMIT = 2'd2;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WACK  = 2'd1;
    localparam logic [1:0] KIND_WBACK = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ACCESS,
        ST_WBREAD,
        ST_WBDATA,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_in;     // capture input word, start search at entry 0
        logic search_step; // compare one entry, advance on a miss
        logic do_write;    // perform write on hit or allocate
        logic wb_select;   // select newest entry (count-1) for write-back
        logic wb_next;     // advance to next older entry
        logic clear;       // empty the table
        logic build_out;   // latch result into output register
        logic [1:0] out_kind;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] func;
        logic       search_done;
        logic       empty;
        logic       wb_last;
    } t_stat;

endpackage

[rtl/core/wrb_ram.sv]
// generic single port ram with registered read
module wrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[rtl/core/wrb_datapath.sv]
// entry table, byte stores and result register
module wrb_datapath import wrb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_home_addr,
    input  logic [1:0]  i_access_size,
    input  logic [15:0] i_write_value,
    output logic [1:0]  o_kind,
    output logic        o_overflow,
    output logic        o_hit,
    output logic [15:0] o_data,
    output logic [7:0]  o_buffer_offset,
    output logic [15:0] o_target_addr,
    output logic [1:0]  o_data_size,
    output logic        o_last
);
    logic [1:0]  r_func;
    logic [15:0] r_addr;
    logic [1:0]  r_size;
    logic [15:0] r_value;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_ptr;
    logic [IDX_W-1:0] r_idx;
    logic        r_found;
    logic [NXT_W-1:0] r_next;

    // entry table as registers, one compare a cycle
    logic [15:0]      r_home [MAX_ENTRIES];
    logic [OFF_W-1:0] r_off  [MAX_ENTRIES];
    logic [1:0]       r_esz  [MAX_ENTRIES];

    logic [IDX_W-1:0] sel;
    logic [OFF_W-1:0] e_off;
    logic [1:0]       e_sz;
    logic [1:0]       n_bytes;
    logic             ovf;
    logic             we_lo, we_hi;
    logic [OFF_W-1:0] a_lo, a_hi, b_off;
    logic [7:0]       rd_lo, rd_hi;
    logic [OFF_W-1:0] wr_off;
    logic [NXT_W:0]   need;

    assign sel   = r_idx;
    assign e_off = r_off[sel];
    assign e_sz  = r_esz[sel];
    assign need  = {1'b0, r_next} + {{(NXT_W-1){1'b0}}, r_size};
    assign ovf   = !r_found && ((r_count >= CNT_W'(MAX_ENTRIES))
                   || (need > (NXT_W+1)'(STORE_BYTES)));
    assign n_bytes = r_found ? ((e_sz < r_size) ? e_sz : r_size) : r_size;
    assign wr_off  = r_found ? e_off : r_next[OFF_W-1:0];

    // two byte banks: lo lane of data goes to address off, hi lane to off+1 in the hi bank
    assign b_off = (i_cmd.do_write ? wr_off : e_off);
    assign a_lo  = b_off;
    assign a_hi  = OFF_W'((NXT_W'(b_off) + NXT_W'(1)) % NXT_W'(STORE_BYTES));
    assign we_lo = i_cmd.do_write && !ovf;
    assign we_hi = i_cmd.do_write && !ovf && (n_bytes == 2'd2);

    // one memory per byte lane; both hold a full store copy so the high byte
    // of entry at offset k lives in the hi copy at k+1 and its low byte in the lo copy at k
    logic [7:0] hi_rd_lo, lo_rd_hi;
    wrb_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_lo (
        .i_clk, .i_we(we_lo), .i_addr(a_lo), .i_wdata(r_value[7:0]), .o_rdata(rd_lo));
    wrb_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_hi (
        .i_clk, .i_we(we_hi), .i_addr(a_hi), .i_wdata(r_value[15:8]), .o_rdata(rd_hi));
    assign hi_rd_lo = rd_lo;
    assign lo_rd_hi = rd_hi;

    // NOTE: a byte may be written through either lane; a lane copy can be stale.
    // entries never overlap and each byte is always written by the same lane
    // (low byte of an entry via lo, high byte via hi), so reads are consistent.

    logic [15:0] rd_word;
    assign rd_word = (e_sz == 2'd2) ? {lo_rd_hi, hi_rd_lo} : {8'd0, hi_rd_lo};

    assign o_stat.func        = r_func;
    assign o_stat.search_done = r_found || (r_ptr >= r_count);
    assign o_stat.empty       = (r_count == '0);
    assign o_stat.wb_last     = (r_idx == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_next  <= '0;
        end else begin
            if (i_cmd.do_write && !ovf && !r_found) begin
                r_home[r_count[IDX_W-1:0]] <= r_addr;
                r_off[r_count[IDX_W-1:0]]  <= r_next[OFF_W-1:0];
                r_esz[r_count[IDX_W-1:0]]  <= r_size;
                r_count <= r_count + CNT_W'(1);
                r_next  <= NXT_W'(need);
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_next  <= '0;
            end
        end
        if (i_cmd.load_in) begin
            r_func  <= i_func;
            r_addr  <= i_home_addr;
            r_size  <= (i_access_size == 2'd1) ? 2'd1 : 2'd2;
            r_value <= i_write_value;
            r_ptr   <= '0;
            r_found <= 1'b0;
            r_idx   <= '0;
        end
        if (i_cmd.search_step) begin
            if (r_home[r_ptr[IDX_W-1:0]] == r_addr) begin
                r_found <= 1'b1;
                r_idx   <= r_ptr[IDX_W-1:0];
            end else begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
        end
        if (i_cmd.wb_select) begin
            r_idx <= IDX_W'(r_count - CNT_W'(1));
        end
        if (i_cmd.wb_next) begin
            r_idx <= r_idx - IDX_W'(1);
        end
        if (i_cmd.build_out) begin
            o_kind          <= i_cmd.out_kind;
            o_overflow      <= 1'b0;
            o_hit           <= 1'b0;
            o_data          <= '0;
            o_buffer_offset <= '0;
            o_target_addr   <= '0;
            o_data_size     <= '0;
            o_last          <= 1'b0;
            case (i_cmd.out_kind)
                KIND_READ: begin
                    if (r_found) begin
                        o_hit           <= 1'b1;
                        o_data          <= rd_word;
                        o_buffer_offset <= 8'(e_off);
                        o_data_size     <= e_sz;
                    end
                end
                KIND_WACK: begin
                    o_overflow <= ovf;
                    o_hit      <= r_found;
                    if (!ovf) begin
                        o_buffer_offset <= 8'(wr_off);
                        o_data_size     <= n_bytes;
                    end
                end
                KIND_WBACK: begin
                    o_data          <= rd_word;
                    o_buffer_offset <= 8'(e_off);
                    o_target_addr   <= r_home[sel];
                    o_data_size     <= e_sz;
                    o_last          <= (r_idx == '0);
                end
                default: begin
                    o_last <= 1'b1;
                end
            endcase
        end
    end
endmodule

[rtl/core/wrb_ctrl.sv]
// sequencing state machine
module wrb_ctrl import wrb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_fire,
    input  logic  i_out_ready,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;
    logic   r_commit, n_commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_commit <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_commit <= n_commit;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_commit = r_commit;
        o_cmd    = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                case (i_stat.func)
                    FUNC_READ, FUNC_WRITE: begin
                        if (i_stat.search_done) begin
                            n_state = ST_ACCESS;
                        end else begin
                            o_cmd.search_step = 1'b1;
                        end
                    end
                    FUNC_COMMIT: begin
                        if (i_stat.empty) begin
                            o_cmd.build_out = 1'b1;
                            o_cmd.out_kind  = KIND_EMPTY;
                            n_commit = 1'b0;
                            n_state  = ST_OUT;
                        end else begin
                            o_cmd.wb_select = 1'b1;
                            n_state = ST_WBREAD;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_ACCESS: begin
                // ram read issued last cycle by address mux; write, else WBDATA
                if (i_stat.func == FUNC_WRITE) begin
                    o_cmd.do_write  = 1'b1;
                    o_cmd.build_out = 1'b1;
                    o_cmd.out_kind  = KIND_WACK;
                    n_commit = 1'b0;
                    n_state  = ST_OUT;
                end else begin
                    n_state = ST_WBDATA;
                    n_commit = 1'b0;
                end
            end
            ST_WBREAD: begin
                n_commit = 1'b1;
                n_state  = ST_WBDATA;
            end
            ST_WBDATA: begin
                o_cmd.build_out = 1'b1;
                o_cmd.out_kind  = r_commit ? KIND_WBACK : KIND_READ;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_commit && !i_stat.wb_last) begin
                        o_cmd.wb_next = 1'b1;
                        n_state = ST_WBREAD;
                    end else begin
                        if (r_commit) begin
                            o_cmd.clear = 1'b1;
                        end
                        n_commit = 1'b0;
                        n_state  = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

[rtl/core/write_redirect_buffer_top.sv]
// top level of the write redirect buffer
// search checks one entry a cycle, from entry 0 until a hit or the end of the table
// after the search: write acknowledge built in ST_ACCESS, read answer in ST_WBDATA
// commit: each write-back via ST_WBREAD and ST_WBDATA; empty commit built in ST_SEARCH
// one word in flight; next word accepted the cycle after the last result is taken
// reset (i_rst_n low, synchronous) empties the table; store contents stay undefined
module write_redirect_buffer_top import wrb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // func, home_addr, access_size, write_value, pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // overflow, hit, data, buffer_offset, target_addr,
                                       // data_size, pad
    output logic [1:0]  m_axis_tuser,  // kind
    output logic        m_axis_tlast   // last word of a commit
);
    t_cmd  cmd;
    t_stat stat;
    logic        ovf, hit, last;
    logic [15:0] data, tgt;
    logic [7:0]  off;
    logic [1:0]  dsz;

    // control sequencer
    wrb_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_fire   (s_axis_tvalid && s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // table, byte store and result register
    wrb_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_func          (s_axis_tdata[1:0]),
        .i_home_addr     (s_axis_tdata[17:2]),
        .i_access_size   (s_axis_tdata[19:18]),
        .i_write_value   (s_axis_tdata[35:20]),
        .o_kind          (m_axis_tuser),
        .o_overflow      (ovf),
        .o_hit           (hit),
        .o_data          (data),
        .o_buffer_offset (off),
        .o_target_addr   (tgt),
        .o_data_size     (dsz),
        .o_last          (last)
    );

    assign m_axis_tdata = {3'd0, dsz, tgt, off, data, hit, ovf};
    assign m_axis_tlast = last;
endmodule
